// File: rtl/tcprx_pkg.sv
// ----------------------------------------------------------------------------
// tcprx_pkg
// Shared types and constants of the TCP receive state machine: state codes,
// flag bits, segment, connection context and result records.
// ----------------------------------------------------------------------------
package tcprx_pkg;

  localparam int unsigned SeqW   = 32;
  localparam int unsigned WinW   = 16;
  localparam int unsigned StateW = 4;
  localparam int unsigned FlagW  = 8;
  localparam int unsigned StatW  = 2;

  // connection states
  localparam logic [StateW-1:0] ST_CLOSED     = 4'd0;
  localparam logic [StateW-1:0] ST_LISTEN     = 4'd1;
  localparam logic [StateW-1:0] ST_SYN_RECV   = 4'd2;
  localparam logic [StateW-1:0] ST_SYN_SENT   = 4'd3;
  localparam logic [StateW-1:0] ST_ESTAB      = 4'd4;
  localparam logic [StateW-1:0] ST_CLOSE_WAIT = 4'd5;
  localparam logic [StateW-1:0] ST_LAST_ACK   = 4'd6;
  localparam logic [StateW-1:0] ST_FIN_WAIT_1 = 4'd7;
  localparam logic [StateW-1:0] ST_FIN_WAIT_2 = 4'd8;
  localparam logic [StateW-1:0] ST_CLOSING    = 4'd9;
  localparam logic [StateW-1:0] ST_TIME_WAIT  = 4'd10;

  // flag bits
  localparam logic [FlagW-1:0] FLAG_NONE = 8'h00;
  localparam logic [FlagW-1:0] FLAG_FIN  = 8'h01;
  localparam logic [FlagW-1:0] FLAG_SYN  = 8'h02;
  localparam logic [FlagW-1:0] FLAG_RST  = 8'h04;
  localparam logic [FlagW-1:0] FLAG_PSH  = 8'h08;
  localparam logic [FlagW-1:0] FLAG_ACK  = 8'h10;

  localparam int unsigned RstBit = 2;

  // request kinds
  localparam logic REQ_SEGMENT   = 1'b0;
  localparam logic REQ_SET_STATE = 1'b1;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 2'd0,
    STAT_DROPPED  = 2'd1,
    STAT_BADFLAGS = 2'd2
  } status_e;

  typedef struct packed {
    logic              req_type;
    logic [StateW-1:0] new_state;
    logic [FlagW-1:0]  flags;
    logic [SeqW-1:0]   seq;
    logic [SeqW-1:0]   seq_end;
    logic [SeqW-1:0]   ack;
    logic [WinW-1:0]   peer_window;
    logic [WinW-1:0]   payload_length;
    logic [SeqW-1:0]   send_next;
    logic [WinW-1:0]   local_window;
  } seg_t;

  typedef struct packed {
    logic [StateW-1:0] state;
    logic [SeqW-1:0]   recv_next;
    logic [SeqW-1:0]   send_unacked;
    logic [WinW-1:0]   send_window;
  } conn_t;

  typedef struct packed {
    logic in_window;
    logic ack_ok;
  } seq_chk_t;

  typedef struct packed {
    logic [FlagW-1:0] reply_flags;
    logic             reply_reset;
    logic             spawn_child;
    logic [SeqW-1:0]  child_recv_next;
    conn_t            conn;
    logic             deliver_payload;
    logic             start_timewait;
    logic             release_conn;
    status_e          status;
  } result_t;

endpackage

// File: rtl/tcprx_seq_check.sv
// ----------------------------------------------------------------------------
// tcprx_seq_check
// Serial-arithmetic checks: segment inside the receive window, and ack
// between the oldest unacked sequence and the next send sequence.
// ----------------------------------------------------------------------------
module tcprx_seq_check (
  input  tcprx_pkg::seg_t     seg_i,
  input  tcprx_pkg::conn_t    conn_i,
  output tcprx_pkg::seq_chk_t chk_o
);
  import tcprx_pkg::*;

  logic [WinW-1:0] win;
  logic [SeqW-1:0] rcv_end;
  logic [SeqW-1:0] d_seq_end;
  logic [SeqW-1:0] d_end_nxt;
  logic [SeqW-1:0] d_una_ack;
  logic [SeqW-1:0] d_ack_nxt;

  // zero window still admits one sequence number
  assign win       = (seg_i.local_window == '0) ? WinW'(1) : seg_i.local_window;
  assign rcv_end   = conn_i.recv_next + {{(SeqW-WinW){1'b0}}, win};
  assign d_seq_end = seg_i.seq - rcv_end;
  assign d_end_nxt = seg_i.seq_end - conn_i.recv_next;
  assign d_una_ack = seg_i.ack - conn_i.send_unacked;
  assign d_ack_nxt = seg_i.send_next - seg_i.ack;

  assign chk_o.in_window = d_seq_end[SeqW-1] && !d_end_nxt[SeqW-1];
  assign chk_o.ack_ok    = !d_una_ack[SeqW-1] && !d_ack_nxt[SeqW-1];

endmodule

// File: rtl/tcprx_update.sv
// ----------------------------------------------------------------------------
// tcprx_update
// Per-state decision logic: next connection context and the actions and
// status for one segment or state-set request.
// ----------------------------------------------------------------------------
module tcprx_update (
  input  tcprx_pkg::seg_t    seg_i,
  input  tcprx_pkg::conn_t   conn_i,
  output tcprx_pkg::result_t res_o
);
  import tcprx_pkg::*;

  seq_chk_t chk;
  result_t  r;
  logic [WinW-1:0] safe_wnd;

  tcprx_seq_check u_seq_check (
    .seg_i  (seg_i),
    .conn_i (conn_i),
    .chk_o  (chk)
  );

  assign safe_wnd = chk.ack_ok ? seg_i.peer_window : conn_i.send_window;

  always_comb begin
    r                 = '0;
    r.conn            = conn_i;
    r.status          = STAT_OK;
    if (seg_i.req_type == REQ_SET_STATE) begin
      if (seg_i.new_state <= ST_TIME_WAIT) begin
        r.conn.state = seg_i.new_state;
      end
    end else if (seg_i.flags[RstBit]) begin
      r.release_conn = 1'b1;
      r.conn.state   = ST_CLOSED;
    end else begin
      unique case (conn_i.state)
        ST_CLOSED: begin
          r.reply_reset = 1'b1;
        end
        ST_LISTEN: begin
          if (seg_i.flags == FLAG_SYN) begin
            r.spawn_child     = 1'b1;
            r.child_recv_next = seg_i.seq + SeqW'(1);
            r.reply_flags     = FLAG_ACK | FLAG_SYN;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_SYN_RECV: begin
          if (seg_i.flags == FLAG_ACK) begin
            r.conn.recv_next    = seg_i.seq_end;
            r.conn.send_window  = seg_i.peer_window;
            r.conn.send_unacked = seg_i.ack;
            r.conn.state        = ST_ESTAB;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_SYN_SENT: begin
          if (seg_i.flags == (FLAG_SYN | FLAG_ACK)) begin
            r.conn.recv_next    = seg_i.seq_end;
            r.conn.send_unacked = seg_i.ack;
            r.conn.send_window  = seg_i.peer_window;
            r.reply_flags       = FLAG_ACK;
            r.conn.state        = ST_ESTAB;
          end else if (seg_i.flags == FLAG_SYN) begin
            r.reply_flags = FLAG_SYN | FLAG_ACK;
            r.conn.state  = ST_SYN_RECV;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_ESTAB: begin
          if (!chk.in_window) begin
            r.status = STAT_DROPPED;
          end else if (seg_i.flags == FLAG_FIN) begin
            r.conn.recv_next = seg_i.seq_end;
            r.reply_flags    = FLAG_ACK;
            r.conn.state     = ST_CLOSE_WAIT;
          end else if (seg_i.flags == (FLAG_PSH | FLAG_ACK)) begin
            r.conn.send_window  = safe_wnd;
            r.conn.send_unacked = seg_i.ack;
            r.conn.recv_next    = seg_i.seq_end;
            r.deliver_payload   = (seg_i.payload_length != '0);
            r.reply_flags       = FLAG_ACK;
          end else if (seg_i.flags == FLAG_ACK) begin
            r.conn.send_window = safe_wnd;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_LAST_ACK: begin
          if (seg_i.flags == FLAG_ACK) begin
            r.conn.send_window  = safe_wnd;
            r.conn.send_unacked = seg_i.ack;
            r.conn.recv_next    = seg_i.seq_end;
            r.conn.state        = ST_CLOSED;
            r.release_conn      = 1'b1;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_FIN_WAIT_1: begin
          if (seg_i.flags == FLAG_ACK) begin
            r.conn.send_window  = safe_wnd;
            r.conn.send_unacked = seg_i.ack;
            r.conn.recv_next    = seg_i.seq_end;
            r.conn.state        = ST_FIN_WAIT_2;
          end else if (seg_i.flags == FLAG_FIN) begin
            // simultaneous close, recv_next stays
            r.reply_flags = FLAG_ACK;
            r.conn.state  = ST_CLOSING;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_FIN_WAIT_2: begin
          if (seg_i.flags == FLAG_FIN) begin
            r.conn.recv_next = seg_i.seq_end;
            r.reply_flags    = FLAG_ACK;
            r.conn.state     = ST_TIME_WAIT;
            r.start_timewait = 1'b1;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_CLOSING: begin
          if (!chk.in_window) begin
            r.status = STAT_DROPPED;
          end else if (seg_i.flags == FLAG_ACK) begin
            r.conn.send_window  = safe_wnd;
            r.conn.send_unacked = seg_i.ack;
            r.conn.recv_next    = seg_i.seq_end;
            r.conn.state        = ST_TIME_WAIT;
            r.start_timewait    = 1'b1;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        // close-wait and time-wait reject every segment without RST
        default: begin
          r.status = STAT_BADFLAGS;
        end
      endcase
    end
  end

  assign res_o = r;

endmodule

// File: rtl/tcprx_top_unused_guard.sv
// ----------------------------------------------------------------------------
// tcprx_top_unused_guard
// Output register stage of the receive state machine: holds one finished
// result until the downstream side takes it.
// ----------------------------------------------------------------------------
module tcprx_top_unused_guard (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  tcprx_pkg::result_t res_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               free_o,
  output tcprx_pkg::result_t res_o
);
  import tcprx_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (free_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// File: rtl/tcp_receive_state_machine.sv
// ----------------------------------------------------------------------------
// tcp_receive_state_machine
// Receive-side TCP connection state machine for one connection.
// ----------------------------------------------------------------------------
// An item (segment header or state-set request) is captured in an input
// register, decided against the connection context, and the result lands in
// an output register; the context is written in the same cycle as that
// register, so the next item sees it. One item per cycle is sustained while
// the output is not stalled; an item moves from the input register to the
// output register once that is free. The context loop (serial compares and per-state select) sets that rate.
// fresh_iss_i belongs to a spawned child and does not affect this connection.
module tcp_receive_state_machine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [3:0]  new_state_i,
  input  logic [7:0]  seg_flags_i,
  input  logic [31:0] seg_seq_i,
  input  logic [31:0] seg_seq_end_i,
  input  logic [31:0] seg_ack_i,
  input  logic [15:0] peer_window_i,
  input  logic [15:0] payload_length_i,
  input  logic [31:0] send_next_i,
  input  logic [15:0] local_window_i,
  input  logic [31:0] fresh_iss_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  reply_flags_o,
  output logic        reply_reset_o,
  output logic        spawn_child_o,
  output logic [31:0] child_recv_next_o,
  output logic [3:0]  conn_state_out_o,
  output logic [31:0] recv_next_out_o,
  output logic [31:0] send_unacked_out_o,
  output logic [15:0] send_window_out_o,
  output logic        deliver_payload_o,
  output logic        start_timewait_o,
  output logic        release_conn_o,
  output logic [1:0]  status_o
);
  import tcprx_pkg::*;

  logic    in_accept;
  logic    advance;
  logic    out_free;
  logic    s1_valid_q, s1_valid_d;
  seg_t    seg_in;
  seg_t    s1_q;
  conn_t   conn_q;
  result_t res_d;
  result_t res_q;

  assign seg_in.req_type       = req_type_i;
  assign seg_in.new_state      = new_state_i;
  assign seg_in.flags          = seg_flags_i;
  assign seg_in.seq            = seg_seq_i;
  assign seg_in.seq_end        = seg_seq_end_i;
  assign seg_in.ack            = seg_ack_i;
  assign seg_in.peer_window    = peer_window_i;
  assign seg_in.payload_length = payload_length_i;
  assign seg_in.send_next      = send_next_i;
  assign seg_in.local_window   = local_window_i;

  // input stage drains whenever the result register can take a word
  assign advance    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      conn_q     <= '{state: ST_CLOSED, default: '0};
    end else begin
      s1_valid_q <= s1_valid_d;
      if (advance) begin
        conn_q <= res_d.conn;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= seg_in;
    end
  end

  tcprx_update u_update (
    .seg_i  (s1_q),
    .conn_i (conn_q),
    .res_o  (res_d)
  );

  tcprx_top_unused_guard u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (res_d),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .res_o       (res_q)
  );

  assign reply_flags_o      = res_q.reply_flags;
  assign reply_reset_o      = res_q.reply_reset;
  assign spawn_child_o      = res_q.spawn_child;
  assign child_recv_next_o  = res_q.child_recv_next;
  assign conn_state_out_o   = res_q.conn.state;
  assign recv_next_out_o    = res_q.conn.recv_next;
  assign send_unacked_out_o = res_q.conn.send_unacked;
  assign send_window_out_o  = res_q.conn.send_window;
  assign deliver_payload_o  = res_q.deliver_payload;
  assign start_timewait_o   = res_q.start_timewait;
  assign release_conn_o     = res_q.release_conn;
  assign status_o           = res_q.status;

  // the shown state is always the live context once nothing is in flight
  a_ctx_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(advance) |-> (conn_q == res_q.conn))
    else $error("context register differs from last result");

  a_release_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && release_conn_o |-> conn_state_out_o == ST_CLOSED)
    else $error("release without closed state");

  a_spawn_listen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && spawn_child_o |-> conn_state_out_o == ST_LISTEN
                                  && child_recv_next_o != 32'd0 || !spawn_child_o
                                  || conn_state_out_o == ST_LISTEN)
    else $error("spawn outside listen");

  a_state_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conn_q.state <= ST_TIME_WAIT)
    else $error("connection state out of range");

  a_drop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |->
      reply_flags_o == FLAG_NONE && !deliver_payload_o && !release_conn_o)
    else $error("action on a rejected segment");

endmodule

// File: test/tb_tcp_receive_state_machine.sv
// ----------------------------------------------------------------------------
// tb_tcp_receive_state_machine
// Self-checking bench for the receive-side TCP connection state machine.
// Segment headers and state-set requests are driven through the input
// handshake. Each accepted word updates a local copy of the connection
// context, and the result it should produce is queued. Results leaving the
// block are compared field by field, in order, against that queue. Stimulus
// is a directed walk through every state and corner, then mostly well-formed
// connection traffic aimed at the current state, mixed with raw noise. Both
// sides idle at random, and one long receiver hold fills the block.
// ----------------------------------------------------------------------------
module tb_tcp_receive_state_machine;
  timeunit 1ns;
  timeprecision 1ps;

  import tcprx_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 600000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RX_HOLD_CYCLES = 200;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        req_type_i;
  logic [3:0]  new_state_i;
  logic [7:0]  seg_flags_i;
  logic [31:0] seg_seq_i;
  logic [31:0] seg_seq_end_i;
  logic [31:0] seg_ack_i;
  logic [15:0] peer_window_i;
  logic [15:0] payload_length_i;
  logic [31:0] send_next_i;
  logic [15:0] local_window_i;
  logic [31:0] fresh_iss_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  reply_flags_o;
  logic        reply_reset_o;
  logic        spawn_child_o;
  logic [31:0] child_recv_next_o;
  logic [3:0]  conn_state_out_o;
  logic [31:0] recv_next_out_o;
  logic [31:0] send_unacked_out_o;
  logic [15:0] send_window_out_o;
  logic        deliver_payload_o;
  logic        start_timewait_o;
  logic        release_conn_o;
  logic [1:0]  status_o;

  typedef struct {
    logic        req_type;
    logic [3:0]  new_state;
    logic [7:0]  flags;
    logic [31:0] seq;
    logic [31:0] seq_end;
    logic [31:0] ack;
    logic [15:0] peer_window;
    logic [15:0] payload_length;
    logic [31:0] send_next;
    logic [15:0] local_window;
    logic [31:0] fresh_iss;
  } seg_word_t;

  // local copy of the connection context
  logic [3:0]  mdl_state;
  logic [31:0] mdl_rcv_nxt;
  logic [31:0] mdl_snd_una;
  logic [15:0] mdl_snd_wnd;

  result_t pending_results[$];

  bit          idle_on;
  bit          rx_hold_request;
  int unsigned error_count;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned cycle_count;
  int unsigned n_spawn, n_deliver, n_release, n_timewait, n_dropped, n_badflags;

  tcp_receive_state_machine uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .new_state_i       (new_state_i),
    .seg_flags_i       (seg_flags_i),
    .seg_seq_i         (seg_seq_i),
    .seg_seq_end_i     (seg_seq_end_i),
    .seg_ack_i         (seg_ack_i),
    .peer_window_i     (peer_window_i),
    .payload_length_i  (payload_length_i),
    .send_next_i       (send_next_i),
    .local_window_i    (local_window_i),
    .fresh_iss_i       (fresh_iss_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .reply_flags_o     (reply_flags_o),
    .reply_reset_o     (reply_reset_o),
    .spawn_child_o     (spawn_child_o),
    .child_recv_next_o (child_recv_next_o),
    .conn_state_out_o  (conn_state_out_o),
    .recv_next_out_o   (recv_next_out_o),
    .send_unacked_out_o(send_unacked_out_o),
    .send_window_out_o (send_window_out_o),
    .deliver_payload_o (deliver_payload_o),
    .start_timewait_o  (start_timewait_o),
    .release_conn_o    (release_conn_o),
    .status_o          (status_o)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------- prediction

  function automatic logic seq_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic logic seq_not_after(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return !d[31];
  endfunction

  function automatic logic seg_in_window(input seg_word_t w);
    logic [31:0] wnd_span;
    logic [31:0] wnd_end;
    // a closed local window still admits the next byte
    wnd_span = (w.local_window == 16'd0) ? 32'd1 : {16'd0, w.local_window};
    wnd_end  = mdl_rcv_nxt + wnd_span;
    return seq_before(w.seq, wnd_end) && seq_not_after(mdl_rcv_nxt, w.seq_end);
  endfunction

  // peer window is trusted only when the ack lies in [snd_una, snd_nxt]
  function automatic void take_peer_window(input seg_word_t w);
    if (seq_not_after(mdl_snd_una, w.ack) && seq_not_after(w.ack, w.send_next)) begin
      mdl_snd_wnd = w.peer_window;
    end
  endfunction

  function automatic result_t next_conn_result(input seg_word_t w);
    result_t r;
    r = '0;
    if (w.req_type == REQ_SET_STATE) begin
      if (w.new_state <= ST_TIME_WAIT) mdl_state = w.new_state;
    end else if (w.flags[RstBit]) begin
      r.release_conn = 1'b1;
      mdl_state = ST_CLOSED;
    end else begin
      case (mdl_state)
        ST_CLOSED: r.reply_reset = 1'b1;
        ST_LISTEN: begin
          if (w.flags == FLAG_SYN) begin
            r.spawn_child     = 1'b1;
            r.child_recv_next = w.seq + 32'd1;
            r.reply_flags     = FLAG_SYN | FLAG_ACK;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_SYN_RECV: begin
          if (w.flags == FLAG_ACK) begin
            mdl_rcv_nxt = w.seq_end;
            mdl_snd_wnd = w.peer_window;
            mdl_snd_una = w.ack;
            mdl_state   = ST_ESTAB;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_SYN_SENT: begin
          if (w.flags == (FLAG_SYN | FLAG_ACK)) begin
            mdl_rcv_nxt   = w.seq_end;
            mdl_snd_una   = w.ack;
            mdl_snd_wnd   = w.peer_window;
            r.reply_flags = FLAG_ACK;
            mdl_state     = ST_ESTAB;
          end else if (w.flags == FLAG_SYN) begin
            r.reply_flags = FLAG_SYN | FLAG_ACK;
            mdl_state     = ST_SYN_RECV;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_ESTAB: begin
          if (!seg_in_window(w)) begin
            r.status = STAT_DROPPED;
          end else if (w.flags == FLAG_FIN) begin
            mdl_rcv_nxt   = w.seq_end;
            r.reply_flags = FLAG_ACK;
            mdl_state     = ST_CLOSE_WAIT;
          end else if (w.flags == (FLAG_PSH | FLAG_ACK)) begin
            take_peer_window(w);
            mdl_snd_una       = w.ack;
            mdl_rcv_nxt       = w.seq_end;
            r.deliver_payload = (w.payload_length != 16'd0);
            r.reply_flags     = FLAG_ACK;
          end else if (w.flags == FLAG_ACK) begin
            take_peer_window(w);
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_LAST_ACK: begin
          if (w.flags == FLAG_ACK) begin
            take_peer_window(w);
            mdl_snd_una    = w.ack;
            mdl_rcv_nxt    = w.seq_end;
            mdl_state      = ST_CLOSED;
            r.release_conn = 1'b1;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_FIN_WAIT_1: begin
          if (w.flags == FLAG_ACK) begin
            take_peer_window(w);
            mdl_snd_una = w.ack;
            mdl_rcv_nxt = w.seq_end;
            mdl_state   = ST_FIN_WAIT_2;
          end else if (w.flags == FLAG_FIN) begin
            // simultaneous close, receive-next stays put
            r.reply_flags = FLAG_ACK;
            mdl_state     = ST_CLOSING;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_FIN_WAIT_2: begin
          if (w.flags == FLAG_FIN) begin
            mdl_rcv_nxt      = w.seq_end;
            r.reply_flags    = FLAG_ACK;
            mdl_state        = ST_TIME_WAIT;
            r.start_timewait = 1'b1;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        ST_CLOSING: begin
          if (!seg_in_window(w)) begin
            r.status = STAT_DROPPED;
          end else if (w.flags == FLAG_ACK) begin
            take_peer_window(w);
            mdl_snd_una      = w.ack;
            mdl_rcv_nxt      = w.seq_end;
            mdl_state        = ST_TIME_WAIT;
            r.start_timewait = 1'b1;
          end else begin
            r.status = STAT_BADFLAGS;
          end
        end
        // close-wait and time-wait reject every segment without RST
        default: r.status = STAT_BADFLAGS;
      endcase
    end
    r.conn.state        = mdl_state;
    r.conn.recv_next    = mdl_rcv_nxt;
    r.conn.send_unacked = mdl_snd_una;
    r.conn.send_window  = mdl_snd_wnd;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic seg_word_t random_word();
    seg_word_t w;
    w.req_type       = 1'($urandom_range(0, 1));
    w.new_state      = 4'($urandom_range(0, 15));
    w.flags          = 8'($urandom_range(0, 255));
    w.seq            = $urandom();
    w.seq_end        = $urandom();
    w.ack            = $urandom();
    w.peer_window    = 16'($urandom());
    w.payload_length = 16'($urandom());
    w.send_next      = $urandom();
    w.local_window   = 16'($urandom());
    w.fresh_iss      = $urandom();
    return w;
  endfunction

  function automatic seg_word_t seg_word(input logic [7:0] flags, input logic [31:0] seq,
                                         input logic [31:0] seq_end, input logic [31:0] ack,
                                         input logic [15:0] pwnd, input logic [15:0] plen,
                                         input logic [31:0] snd_nxt, input logic [15:0] lwnd);
    seg_word_t w;
    w                = random_word();
    w.req_type       = REQ_SEGMENT;
    w.flags          = flags;
    w.seq            = seq;
    w.seq_end        = seq_end;
    w.ack            = ack;
    w.peer_window    = pwnd;
    w.payload_length = plen;
    w.send_next      = snd_nxt;
    w.local_window   = lwnd;
    return w;
  endfunction

  function automatic seg_word_t state_word(input logic [3:0] st);
    seg_word_t w;
    w           = random_word();
    w.req_type  = REQ_SET_STATE;
    w.new_state = st;
    return w;
  endfunction

  function automatic logic [7:0] legal_flags(input logic [3:0] st);
    int unsigned k;
    k = $urandom_range(0, 5);
    case (st)
      ST_LISTEN:     return FLAG_SYN;
      ST_SYN_SENT:   return (k < 3) ? (FLAG_SYN | FLAG_ACK) : FLAG_SYN;
      ST_ESTAB:      return (k == 0) ? FLAG_FIN : (k < 4) ? (FLAG_PSH | FLAG_ACK) : FLAG_ACK;
      ST_FIN_WAIT_1: return (k < 3) ? FLAG_ACK : FLAG_FIN;
      ST_FIN_WAIT_2: return FLAG_FIN;
      default:       return FLAG_ACK;
    endcase
  endfunction

  // a word aimed at the current state: mostly the expected flags and
  // sequence numbers near the context, sometimes a state-set request, noise or a reset
  function automatic seg_word_t make_flow_item();
    seg_word_t   w;
    int unsigned dice;
    int unsigned reopen_pct;
    logic [31:0] wnd_span;
    w          = random_word();
    w.req_type = REQ_SEGMENT;
    case (mdl_state) inside
      ST_CLOSED:                   reopen_pct = 60;
      ST_CLOSE_WAIT, ST_TIME_WAIT: reopen_pct = 50;
      ST_LISTEN:                   reopen_pct = 15;
      default:                     reopen_pct = 4;
    endcase
    dice = $urandom_range(0, 99);
    if (dice < reopen_pct) begin
      w.req_type  = REQ_SET_STATE;
      w.new_state = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                                : 4'($urandom_range(0, 10));
      return w;
    end
    if (dice < reopen_pct + 3) begin
      w.flags = w.flags | FLAG_RST;
      return w;
    end
    w.flags = ($urandom_range(0, 99) < 85) ? legal_flags(mdl_state) : (w.flags & ~FLAG_RST);
    if ($urandom_range(0, 99) < 70) w.payload_length = 16'($urandom_range(0, 1500));
    w.local_window = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
    wnd_span = (w.local_window == 16'd0) ? 32'd1 : {16'd0, w.local_window};
    dice = $urandom_range(0, 99);
    if (dice < 80) w.seq = mdl_rcv_nxt + $urandom_range(0, wnd_span - 1);
    else if (dice < 90) w.seq = mdl_rcv_nxt - $urandom_range(1, 3000);
    if ($urandom_range(0, 99) < 85) w.seq_end = w.seq + w.payload_length;
    if ($urandom_range(0, 99) < 75) begin
      w.ack       = mdl_snd_una + $urandom_range(0, 4000);
      w.send_next = ($urandom_range(0, 4) == 0) ? w.ack - $urandom_range(1, 500)
                                                : w.ack + $urandom_range(0, 4000);
    end
    return w;
  endfunction

  task automatic send_word(input seg_word_t w);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 30) gap = pick_idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    req_type_i       <= w.req_type;
    new_state_i      <= w.new_state;
    seg_flags_i      <= w.flags;
    seg_seq_i        <= w.seq;
    seg_seq_end_i    <= w.seq_end;
    seg_ack_i        <= w.ack;
    peer_window_i    <= w.peer_window;
    payload_length_i <= w.payload_length;
    send_next_i      <= w.send_next;
    local_window_i   <= w.local_window;
    fresh_iss_i      <= w.fresh_iss;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(next_conn_result(w));
    words_sent++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_cases();
    idle_on = 1'b0;
    // a reset segment on a closed connection releases it; a plain one is answered with a reset
    send_word(seg_word('1, '1, '1, '1, '1, '1, '1, '1) );
    send_word(seg_word(FLAG_ACK, '1, '1, '1, '1, '1, '1, '1));
    // state request beyond time-wait is ignored
    send_word(state_word(4'd15));
    send_word(state_word(ST_LISTEN));
    // child receive-next wraps past zero, listener stays put
    send_word(seg_word(FLAG_SYN, '1, '1, '0, '0, '0, '0, '0));
    send_word(seg_word(FLAG_SYN | FLAG_ACK, 32'd7, 32'd7, '0, '0, '0, '0, '0));
    send_word(state_word(ST_SYN_SENT));
    send_word(seg_word(FLAG_SYN, 32'd100, 32'd101, 32'd5, 16'd9, '0, 32'd6, 16'd1));
    send_word(seg_word(FLAG_ACK, 32'h1234, 32'hFFFF_FFF0, 32'h1000, '1, '0, '0, '0));
    // full-size payload wrapping the sequence space
    send_word(seg_word(FLAG_PSH | FLAG_ACK, mdl_rcv_nxt, mdl_rcv_nxt + 32'hFFFF,
                       mdl_snd_una + 32'd10, '0, '1, mdl_snd_una + 32'd100, '1));
    // empty payload is not delivered; ack past send-next keeps the window
    send_word(seg_word(FLAG_PSH | FLAG_ACK, mdl_rcv_nxt, mdl_rcv_nxt, mdl_snd_una + 32'd500,
                       16'h1234, '0, mdl_snd_una + 32'd100, 16'd10));
    // one past the right edge of the receive window
    send_word(seg_word(FLAG_ACK, mdl_rcv_nxt + 32'd100, mdl_rcv_nxt + 32'd200, mdl_snd_una,
                       16'h5555, 16'd100, mdl_snd_una, 16'd100));
    // zero local window admits exactly the next byte
    send_word(seg_word(FLAG_ACK, mdl_rcv_nxt, mdl_rcv_nxt, mdl_snd_una, 16'hAAAA, '0,
                       mdl_snd_una + 32'd1, 16'd0));
    send_word(seg_word(FLAG_ACK, mdl_rcv_nxt + 32'd1, mdl_rcv_nxt + 32'd1, mdl_snd_una,
                       16'h0F0F, '0, mdl_snd_una, 16'd0));
    send_word(seg_word(FLAG_SYN, mdl_rcv_nxt, mdl_rcv_nxt, '0, '0, '0, '0, 16'd1));
    send_word(seg_word(FLAG_FIN, mdl_rcv_nxt, mdl_rcv_nxt + 32'd1, '0, '0, '0, '0, 16'd8));
    send_word(seg_word(FLAG_ACK, mdl_rcv_nxt, mdl_rcv_nxt, '0, '0, '0, '0, 16'd8));
    send_word(state_word(ST_LAST_ACK));
    send_word(seg_word(FLAG_ACK, 32'd3, 32'd40, mdl_snd_una + 32'd1, 16'h00FF, '0,
                       mdl_snd_una + 32'd1, 16'd0));
    send_word(state_word(ST_FIN_WAIT_1));
    send_word(seg_word(FLAG_FIN, 32'd5, 32'd9, '0, '0, '0, '0, '0));
    // behind the receive window in closing
    send_word(seg_word(FLAG_ACK, mdl_rcv_nxt - 32'd10, mdl_rcv_nxt - 32'd1, '0, '0, '0, '0, '1));
    send_word(seg_word(FLAG_ACK, mdl_rcv_nxt, mdl_rcv_nxt + 32'd20, mdl_snd_una, 16'd77, '0,
                       mdl_snd_una, '1));
    send_word(seg_word(FLAG_FIN, mdl_rcv_nxt, mdl_rcv_nxt, '0, '0, '0, '0, '1));
    send_word(state_word(ST_FIN_WAIT_1));
    send_word(seg_word(FLAG_ACK, 32'd50, 32'd60, mdl_snd_una, 16'd1, '0, mdl_snd_una, '0));
    send_word(seg_word(FLAG_FIN, 32'd60, 32'd61, '0, '0, '0, '0, '0));
    send_word(state_word(ST_SYN_SENT));
    send_word(seg_word(FLAG_SYN | FLAG_ACK, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF,
                       16'h8000, '0, '0, '0));
  endtask

  task automatic test_connection_flows(input int unsigned n, input bit with_idle);
    idle_on = with_idle;
    repeat (n) send_word(make_flow_item());
  endtask

  // receiver holds off while words keep coming, so the input side backs up
  task automatic test_receiver_hold();
    idle_on         = 1'b0;
    rx_hold_request = 1'b1;
    repeat (120) send_word(make_flow_item());
  endtask

  task automatic test_random_words(input int unsigned n);
    idle_on = 1'b1;
    repeat (n) send_word(random_word());
  endtask

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: result word with nothing expected, state 0x%0h status 0x%0h",
                 $time, conn_state_out_o, status_o);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("reply_flags", 32'(exp_r.reply_flags), 32'(reply_flags_o));
        check_field("reply_reset", 32'(exp_r.reply_reset), 32'(reply_reset_o));
        check_field("spawn_child", 32'(exp_r.spawn_child), 32'(spawn_child_o));
        check_field("child_recv_next", exp_r.child_recv_next, child_recv_next_o);
        check_field("conn_state", 32'(exp_r.conn.state), 32'(conn_state_out_o));
        check_field("recv_next", exp_r.conn.recv_next, recv_next_out_o);
        check_field("send_unacked", exp_r.conn.send_unacked, send_unacked_out_o);
        check_field("send_window", 32'(exp_r.conn.send_window), 32'(send_window_out_o));
        check_field("deliver_payload", 32'(exp_r.deliver_payload), 32'(deliver_payload_o));
        check_field("start_timewait", 32'(exp_r.start_timewait), 32'(start_timewait_o));
        check_field("release_conn", 32'(exp_r.release_conn), 32'(release_conn_o));
        check_field("status", 32'(exp_r.status), 32'(status_o));
        results_seen++;
        n_spawn    += 32'(exp_r.spawn_child);
        n_deliver  += 32'(exp_r.deliver_payload);
        n_release  += 32'(exp_r.release_conn);
        n_timewait += 32'(exp_r.start_timewait);
        if (exp_r.status == STAT_DROPPED) n_dropped++;
        if (exp_r.status == STAT_BADFLAGS) n_badflags++;
      end
    end
  end

  // receiver stall pattern
  initial begin : rx_stall_gen
    int unsigned span;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        out_stall_i <= 1'b1;
        span = RX_HOLD_CYCLES;
      end else if (idle_on && $urandom_range(0, 99) < 30) begin
        out_stall_i <= 1'b1;
        span = pick_idle_len();
      end else begin
        out_stall_i <= 1'b0;
        span = pick_idle_len();
      end
      repeat (span) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stalled, %0d results still outstanding", $time,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    in_valid_i       = 1'b0;
    req_type_i       = REQ_SEGMENT;
    new_state_i      = ST_CLOSED;
    seg_flags_i      = FLAG_NONE;
    seg_seq_i        = '0;
    seg_seq_end_i    = '0;
    seg_ack_i        = '0;
    peer_window_i    = '0;
    payload_length_i = '0;
    send_next_i      = '0;
    local_window_i   = '0;
    fresh_iss_i      = '0;
    out_stall_i      = 1'b0;
    idle_on          = 1'b0;
    rx_hold_request  = 1'b0;
    mdl_state        = ST_CLOSED;
    mdl_rcv_nxt      = '0;
    mdl_snd_una      = '0;
    mdl_snd_wnd      = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_connection_flows(700, 1'b1);
    test_connection_flows(300, 1'b0);
    test_receiver_hold();
    test_random_words(250);
    test_connection_flows(400, 1'b1);
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d words and %0d results: %0d spawns, %0d deliveries, %0d releases,",
             words_sent, results_seen, n_spawn, n_deliver, n_release);
    $display("%0d time-wait starts, %0d out-of-window drops, %0d flag rejects, %0d errors",
             n_timewait, n_dropped, n_badflags, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
